// File: rtl/gcsp_pkg.sv
// ----------------------------------------------------------------------------
// gcsp_pkg
// Types and constants for the serial game controller port core.
// ----------------------------------------------------------------------------
package gcsp_pkg;

  localparam int unsigned ShiftWidth = 24;
  localparam int unsigned PadWidth   = 8;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 8;

  localparam logic [15:0] PortZeroAddr = 16'h4016;
  localparam logic [15:0] PortOneAddr  = 16'h4017;

  localparam logic [PadWidth-1:0]   CoinOpMask   = 8'hF3;
  localparam logic [PadWidth-1:0]   CoinOpStart  = 8'h08;
  localparam logic [ShiftWidth-1:0] SigPortZero  = 24'h080000;
  localparam logic [ShiftWidth-1:0] SigPortOne   = 24'h040000;
  localparam logic [7:0]            MicBit       = 8'h04;

  typedef enum logic [1:0] {
    OP_LATCH = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_COIN_OP     = 2'd0,
    CFG_SWAP_TYPE   = 2'd1,
    CFG_FOUR_PLAYER = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [ShiftWidth-1:0] zero;
    logic [ShiftWidth-1:0] one;
  } port_load_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
  } result_t;

  // Shift register contents for a strobe load.
  function automatic port_load_t load_ports(
    input logic                coin_op,
    input logic [2:0]          swap,
    input logic                four,
    input logic [PadWidth-1:0] p1,
    input logic [PadWidth-1:0] p2,
    input logic [PadWidth-1:0] p3,
    input logic [PadWidth-1:0] p4
  );
    port_load_t            r;
    logic [PadWidth-1:0]   a1;
    logic [PadWidth-1:0]   a2;
    logic [PadWidth-1:0]   s1;
    logic [PadWidth-1:0]   s2;
    logic [PadWidth-1:0]   z;
    logic [PadWidth-1:0]   o;
    a1 = p1 & CoinOpMask;
    a2 = p2 & CoinOpMask;
    s1 = {5'b0, p1[3], 2'b0};
    s2 = {5'b0, p2[3], 2'b0};
    z  = '0;
    o  = '0;
    case (swap)
      3'd0: begin z = a1 | s1; o = a2 | s2; end
      3'd1: begin z = a2 | s1; o = a1 | s2; end
      3'd2: begin z = a1 | s1 | (s2 << 1); o = a2; end
      3'd3: begin z = a2 | s1 | (s2 << 1); o = a1; end
      3'd4: begin z = a1 | s1 | CoinOpStart; o = a2 | s2 | CoinOpStart; end
      3'd5: begin z = a2 | s1 | CoinOpStart; o = a1 | s2 | CoinOpStart; end
      3'd6: begin
        z = a1 | s1 | {4'b0, p1[2], 3'b0};
        o = a2 | s2 | {4'b0, p2[2], 3'b0};
      end
      default: begin z = '0; o = '0; end
    endcase
    if (coin_op) begin
      r.zero = {16'b0, z};
      r.one  = {16'b0, o};
    end else if (four) begin
      r.zero = {8'b0, p3, p1} | SigPortZero;
      r.one  = {8'b0, p4, p2} | SigPortOne;
    end else begin
      r.zero = {16'b0, p1};
      r.one  = {16'b0, p2};
    end
    return r;
  endfunction

endpackage

// File: rtl/game_controller_serial_port_core.sv
// ----------------------------------------------------------------------------
// game_controller_serial_port_core
// Two-port serial game controller interface with strobe-loaded shift registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction per bus access
//   or frame latch: operation, addr, write_data, pad_one..pad_four and
//   mic_pressed. Every accepted transaction yields exactly one result on the
//   output channel (out_valid/out_ready): read_data and read_valid.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   coin_op_mode, swap_type and four_player; cfg_ready is always high.
//   Result: registered in the output register, or in the skid register if stalled.
//   Throughput: one transaction per cycle while in_ready is high; state updates
//   happen at acceptance, so back-to-back reads shift on consecutive cycles.
//   Stall: a two-entry output buffer (output register plus skid register)
//   keeps accepting while one result waits; in_ready drops only when both
//   entries are full.
//   Reset: rst (synchronous) clears config, strobe, snapshots, shift
//   registers and the output and skid valid flags; result data is not reset.
// ----------------------------------------------------------------------------
module game_controller_serial_port_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] addr,
  input  logic [7:0]  write_data,
  input  logic [7:0]  pad_one,
  input  logic [7:0]  pad_two,
  input  logic [7:0]  pad_three,
  input  logic [7:0]  pad_four,
  input  logic        mic_pressed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic        read_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [gcsp_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic [gcsp_pkg::CfgDataWidth-1:0] cfg_data
);

  logic       coin_op_mode;
  logic [2:0] swap_type;
  logic       four_player;

  logic                             strobe_flag;
  logic [gcsp_pkg::PadWidth-1:0]    pad_snapshot [4];
  logic                             mic_snapshot;
  logic [gcsp_pkg::ShiftWidth-1:0]  port_zero_shift;
  logic [gcsp_pkg::ShiftWidth-1:0]  port_one_shift;
  logic [gcsp_pkg::PadWidth-1:0]    port_zero_extra_shift;
  logic [gcsp_pkg::PadWidth-1:0]    port_one_extra_shift;

  gcsp_pkg::result_t out_reg;
  gcsp_pkg::result_t skid_reg;
  logic              skid_valid;
  gcsp_pkg::result_t result_next;

  gcsp_pkg::op_t        op;
  gcsp_pkg::port_load_t load;
  logic in_fire;
  logic out_fire;
  logic is_zero;
  logic is_one;
  logic do_load;

  assign op        = gcsp_pkg::op_t'(operation);
  assign in_ready  = !skid_valid;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign is_zero   = (addr == gcsp_pkg::PortZeroAddr);
  assign is_one    = (addr == gcsp_pkg::PortOneAddr);
  assign do_load   = (op == gcsp_pkg::OP_WRITE) && is_zero && !write_data[0] && strobe_flag;

  assign load = gcsp_pkg::load_ports(coin_op_mode, swap_type, four_player,
                                     pad_snapshot[0], pad_snapshot[1],
                                     pad_snapshot[2], pad_snapshot[3]);

  always_comb begin
    result_next = '0;
    if (op == gcsp_pkg::OP_READ) begin
      if (is_zero) begin
        result_next.data  = {6'b0, port_zero_extra_shift[0], port_zero_shift[0]};
        if (!coin_op_mode && mic_snapshot) begin
          result_next.data = result_next.data | gcsp_pkg::MicBit;
        end
        result_next.valid = 1'b1;
      end else if (is_one) begin
        result_next.data  = {6'b0, port_one_extra_shift[0], port_one_shift[0]};
        result_next.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coin_op_mode <= 1'b0;
      swap_type    <= '0;
      four_player  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (gcsp_pkg::cfg_idx_t'(cfg_index))
        gcsp_pkg::CFG_COIN_OP:     coin_op_mode <= cfg_data[0];
        gcsp_pkg::CFG_SWAP_TYPE:   swap_type    <= cfg_data[2:0];
        gcsp_pkg::CFG_FOUR_PLAYER: four_player  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_flag           <= 1'b0;
      pad_snapshot[0]       <= '0;
      pad_snapshot[1]       <= '0;
      pad_snapshot[2]       <= '0;
      pad_snapshot[3]       <= '0;
      mic_snapshot          <= 1'b0;
      port_zero_shift       <= '0;
      port_one_shift        <= '0;
      port_zero_extra_shift <= '0;
      port_one_extra_shift  <= '0;
    end else if (in_fire) begin
      case (op)
        gcsp_pkg::OP_LATCH: begin
          pad_snapshot[0] <= pad_one;
          pad_snapshot[1] <= pad_two;
          pad_snapshot[2] <= pad_three;
          pad_snapshot[3] <= pad_four;
          mic_snapshot    <= mic_pressed;
        end
        gcsp_pkg::OP_WRITE: begin
          if (is_zero && write_data[0]) begin
            strobe_flag <= 1'b1;
          end else if (do_load) begin
            strobe_flag           <= 1'b0;
            port_zero_shift       <= load.zero;
            port_one_shift        <= load.one;
            port_zero_extra_shift <= pad_snapshot[2];
            port_one_extra_shift  <= pad_snapshot[3];
          end
        end
        gcsp_pkg::OP_READ: begin
          if (is_zero) begin
            port_zero_shift       <= port_zero_shift >> 1;
            port_zero_extra_shift <= port_zero_extra_shift >> 1;
          end else if (is_one) begin
            port_one_shift        <= port_one_shift >> 1;
            port_one_extra_shift  <= port_one_extra_shift >> 1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register plus skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_reg <= skid_reg;
      end
    end else if (in_fire) begin
      if (!out_valid || out_ready) begin
        out_reg <= result_next;
      end else begin
        skid_reg <= result_next;
      end
    end
  end

  assign read_data  = out_reg.data;
  assign read_valid = out_reg.valid;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without output entry");

  a_read_data_narrow: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (read_data[7:3] == 5'b0) && (read_valid || read_data == 8'h00))
    else $error("result byte has stray bits");

  a_load_drops_strobe: assert property (@(posedge clk) disable iff (rst)
    in_fire && do_load |=> !strobe_flag)
    else $error("strobe still set after load");

  a_shift_on_read: assert property (@(posedge clk) disable iff (rst)
    in_fire && op == gcsp_pkg::OP_READ && is_one
      |=> port_one_shift[gcsp_pkg::ShiftWidth-1] == 1'b0)
    else $error("port one shift not zero filled");

  a_stall_keeps_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(read_valid))
    else $error("stalled result changed");

endmodule
